FILE: rtl/core/bitmap_first_fit_block_allocator_defines.svh
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFFA_ASSERT_NOW(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error("bffa check failed");

// next-cycle implication
`define BFFA_ASSERT_NEXT(label, clk, rst, cond, check) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error("bffa check failed");

`endif

FILE: rtl/core/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

   localparam int unsigned BLK_W       = 12;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned COUNT_RESET = 4096;

   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_MARK  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LOCATE,
      S_ALLOC_WR,
      S_SPLIT,
      S_MODIFY,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [BLK_W-1:0] blk;
      status_type       status;
   } result_type;

endpackage

FILE: rtl/core/bffa_blk_split.sv
`timescale 1ns / 1ps

module bffa_blk_split #(
   parameter int unsigned MAX_BLOCKS = 4096,
   parameter int unsigned WORD_BITS  = 64,
   localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
   localparam int unsigned WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
   localparam int unsigned BIT_W     = $clog2(WORD_BITS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bffa_pkg::BLK_W-1:0] blk,
   output logic                      done,
   output logic [WI_W-1:0]           word_idx,
   output logic [BIT_W-1:0]          bit_sel
);
   import bffa_pkg::*;

   // quotient by reciprocal, exact for every 12-bit block number
   localparam int unsigned DIV_SH  = BLK_W + BIT_W;
   localparam int unsigned RECIP   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned RECIP_W = $clog2(RECIP + 1);
   localparam int unsigned PROD_W  = BLK_W + RECIP_W;

   logic [PROD_W-1:0] prod;
   logic [BLK_W-1:0]  quot;
   logic [BLK_W-1:0]  q_ff;
   logic [BLK_W-1:0]  blk_d_ff;
   logic [BLK_W-1:0]  qmul;
   logic [BLK_W-1:0]  rem;
   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic [WI_W-1:0]   word_ff;
   logic [BIT_W-1:0]  bit_ff;

   assign prod  = PROD_W'(blk) * PROD_W'(RECIP);
   assign quot  = BLK_W'(prod >> DIV_SH);
   assign qmul  = BLK_W'(q_ff * WORD_BITS);
   assign rem   = blk_d_ff - qmul;
   assign v1_in = start;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= quot;
      blk_d_ff <= blk;
      word_ff  <= WI_W'(q_ff);
      bit_ff   <= BIT_W'(rem);
   end

   assign done     = v2_ff;
   assign word_idx = word_ff;
   assign bit_sel  = bit_ff;

endmodule

FILE: rtl/core/bffa_core.sv
`timescale 1ns / 1ps
`include "bitmap_first_fit_block_allocator_defines.svh"

module bffa_core #(
   parameter int unsigned MAX_BLOCKS = 4096,
   parameter int unsigned WORD_BITS  = 64,
   localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS) + 1,
   localparam int unsigned CMP_W     = (IDX_W > bffa_pkg::COUNT_W) ? IDX_W : bffa_pkg::COUNT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  logic [1:0]                 req_func,
   input  logic [bffa_pkg::BLK_W-1:0] req_block_number,
   input  logic [CMP_W-1:0]           limit,
   input  logic                       slot_free,
   output logic                       busy,
   output logic                       res_valid,
   output bffa_pkg::result_type       res
);
   import bffa_pkg::*;

   localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int unsigned BIT_W     = $clog2(WORD_BITS);
   localparam logic [WI_W-1:0]      LAST_WORD = WI_W'(MAP_WORDS - 1);
   localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] ONE       = WORD_BITS'(1);

   state_type state_ff, state_in;

   logic                 set_ff, set_in;
   logic [WI_W-1:0]      clr_ff, clr_in;
   logic [WI_W-1:0]      scan_addr_ff, scan_addr_in;
   logic [IDX_W-1:0]     issue_base_ff, issue_base_in;
   logic                 issue_more_ff, issue_more_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic                 chk_last_ff, chk_last_in;
   logic [WI_W-1:0]      chk_addr_ff, chk_addr_in;
   logic [IDX_W-1:0]     chk_base_ff, chk_base_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [WI_W-1:0]      word_addr_ff, word_addr_in;
   logic [IDX_W-1:0]     cand_ff, cand_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   result_type           res_ff, res_in;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic                 rd_en;
   logic [WI_W-1:0]      rd_addr;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [WI_W-1:0]      wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic                 split_start;
   logic                 split_done;
   logic [WI_W-1:0]      split_word;
   logic [BIT_W-1:0]     split_bit;

   logic                 is_alloc;
   logic                 is_single;
   logic                 in_range;
   logic                 scan_over;
   logic                 scan_hit;
   logic                 scan_end;
   logic [WORD_BITS-1:0] lowest_zero;
   logic [BIT_W-1:0]     lz_idx;
   logic [WORD_BITS-1:0] bit_mask;

   bffa_blk_split #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_split (
      .clock    (clock),
      .reset    (reset),
      .start    (split_start),
      .blk      (req_block_number),
      .done     (split_done),
      .word_idx (split_word),
      .bit_sel  (split_bit)
   );

   assign is_alloc  = (req_func == FUNC_ALLOC);
   assign is_single = (req_func == FUNC_FREE) || (req_func == FUNC_MARK);
   assign in_range  = (CMP_W'(req_block_number) < limit);

   // a word at or past the limit can only give a block that is out of range
   assign scan_over = chk_valid_ff && (CMP_W'(chk_base_ff) >= limit);
   assign scan_hit  = chk_valid_ff && !scan_over && (rd_data_ff != ONES);
   assign scan_end  = chk_valid_ff && !scan_over && (rd_data_ff == ONES) && chk_last_ff;

   assign lowest_zero = ~word_ff & (word_ff + ONE);
   assign bit_mask    = ONE << bit_ff;

   always_comb begin
      lz_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest_zero[i]) begin
            lz_idx = lz_idx | BIT_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               priority if (is_alloc) begin
                  state_in = S_SCAN;
               end else if (is_single && in_range) begin
                  state_in = S_SPLIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            priority if (scan_hit) begin
               state_in = S_LOCATE;
            end else if (scan_over || scan_end) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_LOCATE:   state_in = S_ALLOC_WR;
         S_ALLOC_WR: state_in = S_DONE;
         S_SPLIT: begin
            if (split_done) begin
               state_in = S_MODIFY;
            end
         end
         S_MODIFY:   state_in = S_DONE;
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      set_in        = set_ff;
      clr_in        = clr_ff;
      scan_addr_in  = scan_addr_ff;
      issue_base_in = issue_base_ff;
      issue_more_in = issue_more_ff;
      chk_valid_in  = chk_valid_ff;
      chk_last_in   = chk_last_ff;
      chk_addr_in   = chk_addr_ff;
      chk_base_in   = chk_base_ff;
      word_in       = word_ff;
      word_addr_in  = word_addr_ff;
      cand_in       = cand_ff;
      bit_in        = bit_ff;
      res_in        = res_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = '0;
      split_start   = 1'b0;
      res_valid     = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + WI_W'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               set_in = (req_func == FUNC_MARK);
               res_in = '{blk: req_block_number, status: STAT_RANGE};
               if (is_alloc) begin
                  scan_addr_in  = '0;
                  issue_base_in = '0;
                  issue_more_in = 1'b1;
                  chk_valid_in  = 1'b0;
               end else if (is_single && in_range) begin
                  split_start = 1'b1;
               end
            end
         end
         S_SCAN: begin
            // one word read per cycle, checked the cycle after
            rd_en        = issue_more_ff;
            rd_addr      = scan_addr_ff;
            chk_valid_in = issue_more_ff;
            chk_addr_in  = scan_addr_ff;
            chk_base_in  = issue_base_ff;
            chk_last_in  = (scan_addr_ff == LAST_WORD);
            if (issue_more_ff) begin
               scan_addr_in  = scan_addr_ff + WI_W'(1);
               issue_base_in = issue_base_ff + IDX_W'(WORD_BITS);
               issue_more_in = (scan_addr_ff != LAST_WORD);
            end
            if (scan_hit) begin
               word_in      = rd_data_ff;
               word_addr_in = chk_addr_ff;
               cand_in      = chk_base_ff;
            end
            if (scan_over || scan_end) begin
               res_in = '{blk: '0, status: STAT_FULL};
            end
         end
         S_LOCATE: begin
            bit_in  = lz_idx;
            cand_in = cand_ff + IDX_W'(lz_idx);
         end
         S_ALLOC_WR: begin
            if (CMP_W'(cand_ff) >= limit) begin
               res_in = '{blk: '0, status: STAT_FULL};
            end else begin
               wr_en   = 1'b1;
               wr_addr = word_addr_ff;
               wr_data = word_ff | bit_mask;
               res_in  = '{blk: BLK_W'(cand_ff), status: STAT_OK};
            end
         end
         S_SPLIT: begin
            if (split_done) begin
               rd_en        = 1'b1;
               rd_addr      = split_word;
               word_addr_in = split_word;
               bit_in       = split_bit;
            end
         end
         S_MODIFY: begin
            wr_en   = 1'b1;
            wr_addr = word_addr_ff;
            wr_data = set_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
            res_in  = '{blk: res_ff.blk, status: STAT_OK};
         end
         S_DONE: begin
            res_valid = slot_free;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         issue_more_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         issue_more_ff <= issue_more_in;
         chk_valid_ff  <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff        <= set_in;
      scan_addr_ff  <= scan_addr_in;
      issue_base_ff <= issue_base_in;
      chk_last_ff   <= chk_last_in;
      chk_addr_ff   <= chk_addr_in;
      chk_base_ff   <= chk_base_in;
      word_ff       <= word_in;
      word_addr_ff  <= word_addr_in;
      cand_ff       <= cand_in;
      bit_ff        <= bit_in;
      res_ff        <= res_in;
   end

   // bitmap memory, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign res  = res_ff;

   `BFFA_ASSERT_NOW(a_no_rw_same_word, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   `BFFA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != S_IDLE)
   `BFFA_ASSERT_NOW(a_split_done_in_split, clock, reset, split_done, state_ff == S_SPLIT)

endmodule

FILE: rtl/core/bitmap_first_fit_block_allocator.sv
`timescale 1ns / 1ps
`include "bitmap_first_fit_block_allocator_defines.svh"

// Bitmap first-fit block allocator: one used bit per block, held in a single-port-read,
// single-port-write memory of MAX_BLOCKS/WORD_BITS words. Allocate (func 0) returns the
// lowest free block below the volume size and marks it, or status 1 when there is none;
// free (func 1) and mark (func 2) clear or set one bit, status 2 when the block is at or
// above the volume size, as is any other func code. The volume size is written on the
// csr channel (block_count, capped at MAX_BLOCKS); the user must write it only while the
// block is idle, which the block itself does not enforce. csr_ready is always high. One
// request is worked at a time. An allocate reads one bitmap word per cycle, the scan
// stopping early at the first word with a clear bit or at the volume size; a free or
// mark runs the reciprocal word/bit split, issues the read when the split is done, then
// does a write-back. A finished result sits in an output register, so the next request
// is taken while it waits. After reset the bitmap is cleared one word per cycle, with
// req_stall high throughout.

module bitmap_first_fit_block_allocator #(
   parameter int unsigned MAX_BLOCKS = 4096,
   parameter int unsigned WORD_BITS  = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic [bffa_pkg::BLK_W-1:0]   req_block_number,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bffa_pkg::BLK_W-1:0]   rsp_result_block,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bffa_pkg::COUNT_W-1:0] csr_block_count
);
   import bffa_pkg::*;

   localparam int unsigned IDX_W       = $clog2(MAX_BLOCKS) + 1;
   localparam int unsigned CMP_W       = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
   localparam int unsigned LIMIT_RESET = (COUNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : COUNT_RESET;
   localparam logic [CMP_W-1:0] LIMIT_MAX = CMP_W'(MAX_BLOCKS);

   logic [CMP_W-1:0] limit_ff, limit_in;
   logic [CMP_W-1:0] count_ext;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0] rsp_blk_ff;
   status_type       rsp_status_ff;
   logic             req_accept;
   logic             slot_free;
   logic             core_busy;
   logic             core_res_valid;
   result_type       core_res;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = core_busy;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // volume size, capped to the bitmap
   assign count_ext = CMP_W'(csr_block_count);
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = (count_ext > LIMIT_MAX) ? LIMIT_MAX : count_ext;
      end
   end

   always_comb begin
      priority if (core_res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   bffa_core #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .req_accept       (req_accept),
      .req_func         (req_func),
      .req_block_number (req_block_number),
      .limit            (limit_ff),
      .slot_free        (slot_free),
      .busy             (core_busy),
      .res_valid        (core_res_valid),
      .res              (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= CMP_W'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_res_valid) begin
         rsp_blk_ff    <= core_res.blk;
         rsp_status_ff <= core_res.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_blk_ff;
   assign rsp_status       = rsp_status_ff;

   `BFFA_ASSERT_NOW(a_full_gives_zero, clock, reset, rsp_valid_ff && rsp_status_ff == STAT_FULL, rsp_blk_ff == '0)
   `BFFA_ASSERT_NOW(a_load_only_when_free, clock, reset, core_res_valid, !rsp_valid_ff || !rsp_stall)
   `BFFA_ASSERT_NOW(a_limit_capped, clock, reset, 1'b1, limit_ff <= LIMIT_MAX)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import bffa_pkg::*;

   localparam int unsigned MAP_BLOCKS     = 4096;
   localparam int unsigned MAP_WORD_BITS  = 64;
   localparam int unsigned PHASE_COUNT    = 12;
   localparam int unsigned PHASE_REQUESTS = 161;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned SETTLE_CYCLES  = 80;
   localparam int unsigned STALL_LIMIT    = 4000;
   localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

   // bitmap predictor and queue of outstanding allocator results
   class alloc_scoreboard;
      bit                used [MAP_BLOCKS];
      int unsigned       block_count;
      result_type        pending_q[$];
      int unsigned       failures;

      function new();
         foreach (used[i]) used[i] = 1'b0;
         block_count = COUNT_RESET;
         failures = 0;
      endfunction

      function void set_block_count(logic [COUNT_W-1:0] value);
         block_count = value;
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      function void note_request(logic [1:0] func, logic [BLK_W-1:0] blk);
         result_type  e;
         int unsigned lim;
         int unsigned k;
         bit          found;
         lim = (block_count > MAP_BLOCKS) ? MAP_BLOCKS : block_count;
         e.blk = blk;
         e.status = STAT_OK;
         case (func)
            FUNC_ALLOC: begin
               found = 1'b0;
               e.blk = '0;
               // first-fit: lowest clear bit below the volume size
               for (k = 0; k < lim && !found; k++) begin
                  if (!used[k]) begin
                     found = 1'b1;
                     e.blk = k[BLK_W-1:0];
                  end
               end
               if (found) used[e.blk] = 1'b1;
               else e.status = STAT_FULL;
            end
            FUNC_FREE, FUNC_MARK: begin
               if (blk >= lim) e.status = STAT_RANGE;
               else used[blk] = (func == FUNC_MARK);
            end
            default: e.status = STAT_RANGE;
         endcase
         pending_q.push_back(e);
      endfunction

      function void check_result(logic [BLK_W-1:0] blk, logic [1:0] status);
         result_type e;
         if (pending_q.size() == 0) begin
            flag($sformatf("unexpected result: blk %0d status %0d", blk, status));
            return;
         end
         e = pending_q.pop_front();
         if (blk !== e.blk || status !== e.status)
            flag($sformatf("result mismatch: expected blk %0d status %0d, got blk %0d status %0d",
                           e.blk, e.status, blk, status));
      endfunction

      function void check_leftover();
         if (pending_q.size() != 0)
            flag($sformatf("%0d results never arrived", pending_q.size()));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic [BLK_W-1:0]   req_block_number;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [BLK_W-1:0]   rsp_result_block;
   logic [1:0]         rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_block_count;

   alloc_scoreboard sb = new();
   int unsigned     send_idle_pct;
   int unsigned     recv_idle_pct;
   bit              long_hold_req;

   always #6 clock = ~clock;

   bitmap_first_fit_block_allocator #(
      .MAX_BLOCKS(MAP_BLOCKS),
      .WORD_BITS (MAP_WORD_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_block_number(req_block_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_block(rsp_result_block),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_block_count (csr_block_count)
   );

   task automatic send_request(input logic [1:0] func, input logic [BLK_W-1:0] blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_block_number <= blk;
      do @(posedge clock); while (req_stall);
      sb.note_request(func, blk);
   endtask

   // sender holds off until every result is back, then the register is written
   task automatic write_block_count(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_block_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_block_count(value);
   endtask

   function automatic logic [BLK_W-1:0] pick_block(input int unsigned lim);
      int unsigned r;
      r = $urandom_range(9);
      if (lim == 0 || r >= 8) return BLK_W'($urandom);
      // bias towards low blocks so frees mostly hit allocated ones
      if (r < 4 && lim > 256) return BLK_W'($urandom_range(255));
      return BLK_W'($urandom_range(((lim > MAP_BLOCKS) ? MAP_BLOCKS : lim) - 1));
   endfunction

   task automatic send_random(input int unsigned count, input int unsigned lim);
      int unsigned r;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 45) send_request(FUNC_ALLOC, BLK_W'($urandom));
         else if (r < 75) send_request(FUNC_FREE, pick_block(lim));
         else if (r < 93) send_request(FUNC_MARK, pick_block(lim));
         else send_request(FUNC_UNUSED, BLK_W'($urandom));
      end
   endtask

   // result side: random stall plus an occasional long hold-off
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_result_block, rsp_status);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [COUNT_W-1:0] phase_counts [PHASE_COUNT];
      int unsigned        p;
      phase_counts = '{13'd1, 13'd64, 13'd4096, 13'd65, 13'd2, 13'd8191,
                       13'd130, 13'd0, 13'd4097, 13'd200, 13'd63, 13'd4096};
      phase_counts[9] = COUNT_W'($urandom_range(300, 1));
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_ALLOC;
      req_block_number = '0;
      csr_valid = 1'b0;
      csr_block_count = '0;
      long_hold_req = 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 52;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full volume after reset
      send_request(FUNC_ALLOC, 12'd4095);
      send_request(FUNC_ALLOC, 12'd0);
      send_request(FUNC_ALLOC, 12'd77);
      send_request(FUNC_FREE, 12'd1);
      send_request(FUNC_ALLOC, 12'd0);
      send_request(FUNC_MARK, 12'd4095);
      send_request(FUNC_FREE, 12'd4095);
      send_request(FUNC_FREE, 12'd4095);
      send_request(FUNC_MARK, 12'd2);
      send_request(FUNC_UNUSED, 12'd4095);
      send_request(FUNC_UNUSED, 12'd0);
      // zero volume size
      write_block_count(13'd0);
      send_request(FUNC_ALLOC, 12'd0);
      send_request(FUNC_FREE, 12'd0);
      send_request(FUNC_MARK, 12'd4095);
      // register above the bitmap size
      write_block_count(13'd8191);
      send_request(FUNC_MARK, 12'd4095);
      send_request(FUNC_ALLOC, 12'd4095);
      // single block volume, block 0 already used
      write_block_count(13'd1);
      send_request(FUNC_ALLOC, 12'd0);
      send_request(FUNC_FREE, 12'd0);
      send_request(FUNC_ALLOC, 12'd0);
      send_request(FUNC_MARK, 12'd1);
      // shrunk volume with higher bits left set
      write_block_count(13'd3);
      send_request(FUNC_ALLOC, 12'd0);
      send_request(FUNC_FREE, 12'd3);
      send_request(FUNC_FREE, 12'd2);
      send_request(FUNC_ALLOC, 12'd0);

      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p < 4) begin
            send_idle_pct = 26;
            recv_idle_pct = 52;
         end else if (p < 8) begin
            send_idle_pct = 52;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_block_count(phase_counts[p]);
         if (p == 2 || p == 9) long_hold_req = 1'b1;
         send_random(PHASE_REQUESTS, phase_counts[p]);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.check_leftover();
      if (sb.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
